FILE: rtl/core/ppid_pkg.sv
package ppid_pkg;

    localparam int DATA_W = 32;
    localparam int DIV_W  = 16;
    localparam int PC_W   = 4;
    localparam int DIV_STEPS = 32;
    localparam int CNT_W  = 5;

    typedef enum logic [3:0] {
        OP_LOAD     = 4'd0,
        OP_INTEG    = 4'd1,
        OP_MUL_P    = 4'd2,
        OP_MAC_I    = 4'd3,
        OP_MAC_D    = 4'd4,
        OP_ACC      = 4'd5,
        OP_DIV_INIT = 4'd6,
        OP_DIV_STEP = 4'd7,
        OP_EMIT     = 4'd8,
        OP_NOP      = 4'd9
    } t_op;

    typedef enum logic [2:0] {
        C_NEXT     = 3'd0,
        C_NO_START = 3'd1,
        C_DIV_MORE = 3'd2,
        C_OUT_BUSY = 3'd3,
        C_ALWAYS   = 3'd4
    } t_cond;

    typedef struct packed {
        t_op              op;
        t_cond            cond;
        logic [PC_W-1:0]  target;
    } t_ctrl;

    typedef struct packed {
        logic div_more;
        logic out_busy;
    } t_stat;

    localparam logic [PC_W-1:0] S_WAIT = 4'd0;
    localparam logic [PC_W-1:0] S_DIV  = 4'd7;
    localparam logic [PC_W-1:0] S_EMIT = 4'd8;

    // microprogram: one control word per step
    function automatic t_ctrl rom_word(logic [PC_W-1:0] pc);
        t_ctrl w;
        w = '{op: OP_NOP, cond: C_ALWAYS, target: S_WAIT};
        case (pc)
            4'd0: w = '{op: OP_LOAD,     cond: C_NO_START, target: S_WAIT};
            4'd1: w = '{op: OP_INTEG,    cond: C_NEXT,     target: S_WAIT};
            4'd2: w = '{op: OP_MUL_P,    cond: C_NEXT,     target: S_WAIT};
            4'd3: w = '{op: OP_MAC_I,    cond: C_NEXT,     target: S_WAIT};
            4'd4: w = '{op: OP_MAC_D,    cond: C_NEXT,     target: S_WAIT};
            4'd5: w = '{op: OP_ACC,      cond: C_NEXT,     target: S_WAIT};
            4'd6: w = '{op: OP_DIV_INIT, cond: C_NEXT,     target: S_WAIT};
            4'd7: w = '{op: OP_DIV_STEP, cond: C_DIV_MORE, target: S_DIV};
            4'd8: w = '{op: OP_EMIT,     cond: C_OUT_BUSY, target: S_EMIT};
            4'd9: w = '{op: OP_NOP,      cond: C_ALWAYS,   target: S_WAIT};
            default: w = '{op: OP_NOP,   cond: C_ALWAYS,   target: S_WAIT};
        endcase
        return w;
    endfunction

endpackage

FILE: rtl/core/ppid_seq.sv
module ppid_seq (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  ppid_pkg::t_stat       i_stat,
    output ppid_pkg::t_ctrl       o_ctrl,
    output logic                  o_in_ready
);

    logic [ppid_pkg::PC_W-1:0] r_pc;
    logic [ppid_pkg::PC_W-1:0] n_pc;
    ppid_pkg::t_ctrl           ctrl;
    logic                      take;

    assign ctrl = ppid_pkg::rom_word(r_pc);

    always_comb begin
        case (ctrl.cond)
            ppid_pkg::C_NEXT:     take = 1'b0;
            ppid_pkg::C_NO_START: take = !i_in_valid;
            ppid_pkg::C_DIV_MORE: take = i_stat.div_more;
            ppid_pkg::C_OUT_BUSY: take = i_stat.out_busy;
            ppid_pkg::C_ALWAYS:   take = 1'b1;
            default:              take = 1'b1;
        endcase
        n_pc = take ? ctrl.target : r_pc + 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= ppid_pkg::S_WAIT;
        end else begin
            r_pc <= n_pc;
        end
    end

    assign o_ctrl     = ctrl;
    assign o_in_ready = (ctrl.op == ppid_pkg::OP_LOAD);

endmodule

FILE: rtl/core/ppid_dp.sv
module ppid_dp #(
    parameter int SAMPLE_WIDTH = 16,
    parameter int GAIN_WIDTH   = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  ppid_pkg::t_ctrl                       i_ctrl,
    input  logic                                  i_in_valid,
    input  logic signed [SAMPLE_WIDTH-1:0]        i_setpoint,
    input  logic signed [SAMPLE_WIDTH-1:0]        i_measured,
    input  logic signed [GAIN_WIDTH-1:0]          i_gain_p,
    input  logic signed [GAIN_WIDTH-1:0]          i_gain_i,
    input  logic signed [GAIN_WIDTH-1:0]          i_gain_d,
    input  logic [ppid_pkg::DIV_W-1:0]            i_divisor,
    input  logic signed [ppid_pkg::DATA_W-1:0]    i_integral_floor,
    input  logic signed [ppid_pkg::DATA_W-1:0]    i_integral_ceiling,
    input  logic signed [ppid_pkg::DATA_W-1:0]    i_output_floor,
    input  logic signed [ppid_pkg::DATA_W-1:0]    i_output_ceiling,
    input  logic                                  i_out_ready,
    output ppid_pkg::t_stat                       o_stat,
    output logic                                  o_out_valid,
    output logic signed [ppid_pkg::DATA_W-1:0]    o_drive
);

    localparam int DW     = ppid_pkg::DATA_W;
    localparam int ERR_W  = SAMPLE_WIDTH + 1;
    localparam int DER_W  = SAMPLE_WIDTH + 2;
    localparam int OPD_W  = (DER_W > DW) ? DER_W : DW;
    localparam int PROD_W = GAIN_WIDTH + OPD_W;
    localparam int ACC_W  = PROD_W + 2;
    localparam int QW     = ppid_pkg::DIV_W;

    localparam logic signed [DW-1:0] S_MAX = {1'b0, {(DW-1){1'b1}}};
    localparam logic signed [DW-1:0] S_MIN = {1'b1, {(DW-1){1'b0}}};

    function automatic logic signed [DW-1:0] clamp(
        logic signed [DW-1:0] v, logic signed [DW-1:0] lo, logic signed [DW-1:0] hi);
        logic signed [DW-1:0] r;
        r = v;
        if (lo < hi) begin
            if (v > hi) r = hi;
            else if (v < lo) r = lo;
        end
        return r;
    endfunction

    logic signed [ERR_W-1:0]  r_err;
    logic signed [ERR_W-1:0]  r_prev;
    logic signed [DER_W-1:0]  r_der;
    logic signed [DW-1:0]     r_integ;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [ACC_W-1:0]  r_acc;
    logic [DW-1:0]            r_dvd;
    logic [QW-1:0]            r_rem;
    logic                     r_neg;
    logic [ppid_pkg::CNT_W-1:0] r_cnt;
    logic                     r_out_valid;
    logic signed [DW-1:0]     r_drive;

    logic                     load;
    logic signed [ERR_W-1:0]  n_err;
    logic signed [DW:0]       integ_sum;
    logic signed [DW-1:0]     integ_sat;
    logic signed [GAIN_WIDTH-1:0] mul_a;
    logic signed [OPD_W-1:0]  mul_b;
    logic signed [DW-1:0]     raw;
    logic [ACC_W-DW:0]        acc_top;
    logic [QW:0]              rem_sh;
    logic                     q_bit;
    logic signed [DW-1:0]     quot;

    assign load  = (i_ctrl.op == ppid_pkg::OP_LOAD) && i_in_valid;
    assign n_err = ERR_W'(i_setpoint) - ERR_W'(i_measured);

    // integral update saturates before the clamp
    always_comb begin
        integ_sum = (DW+1)'(r_integ) + (DW+1)'(r_err);
        if (integ_sum[DW] != integ_sum[DW-1]) begin
            integ_sat = integ_sum[DW] ? S_MIN : S_MAX;
        end else begin
            integ_sat = integ_sum[DW-1:0];
        end
    end

    // shared multiplier operand select
    always_comb begin
        case (i_ctrl.op)
            ppid_pkg::OP_MAC_I: begin
                mul_a = i_gain_i;
                mul_b = OPD_W'(r_integ);
            end
            ppid_pkg::OP_MAC_D: begin
                mul_a = i_gain_d;
                mul_b = OPD_W'(r_der);
            end
            default: begin
                mul_a = i_gain_p;
                mul_b = OPD_W'(r_err);
            end
        endcase
    end

    // weighted sum to 32-bit signed
    always_comb begin
        acc_top = r_acc[ACC_W-1:DW-1];
        if (acc_top == '0 || acc_top == '1) begin
            raw = r_acc[DW-1:0];
        end else begin
            raw = r_acc[ACC_W-1] ? S_MIN : S_MAX;
        end
    end

    // one restoring divide step on the magnitude
    always_comb begin
        rem_sh = {r_rem, r_dvd[DW-1]};
        q_bit  = (rem_sh >= {1'b0, i_divisor});
        quot   = r_neg ? -$signed(r_dvd) : $signed(r_dvd);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev      <= '0;
            r_integ     <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (load) begin
                r_prev <= n_err;
            end
            if (i_ctrl.op == ppid_pkg::OP_INTEG) begin
                r_integ <= clamp(integ_sat, i_integral_floor, i_integral_ceiling);
            end
            if (i_ctrl.op == ppid_pkg::OP_DIV_INIT) begin
                r_cnt <= '0;
            end else if (i_ctrl.op == ppid_pkg::OP_DIV_STEP) begin
                r_cnt <= r_cnt + 1'b1;
            end
            if (i_ctrl.op == ppid_pkg::OP_EMIT && !o_stat.out_busy) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_err <= n_err;
            r_der <= DER_W'(n_err) - DER_W'(r_prev);
        end
        case (i_ctrl.op)
            ppid_pkg::OP_INTEG: begin
                r_acc <= '0;
            end
            ppid_pkg::OP_MUL_P: begin
                r_prod <= mul_a * mul_b;
            end
            ppid_pkg::OP_MAC_I, ppid_pkg::OP_MAC_D: begin
                r_acc  <= r_acc + ACC_W'(r_prod);
                r_prod <= mul_a * mul_b;
            end
            ppid_pkg::OP_ACC: begin
                r_acc <= r_acc + ACC_W'(r_prod);
            end
            ppid_pkg::OP_DIV_INIT: begin
                r_neg <= raw[DW-1];
                r_dvd <= raw[DW-1] ? DW'(-raw) : DW'(raw);
                r_rem <= '0;
            end
            ppid_pkg::OP_DIV_STEP: begin
                r_rem <= q_bit ? QW'(rem_sh - {1'b0, i_divisor}) : QW'(rem_sh);
                r_dvd <= {r_dvd[DW-2:0], q_bit};
            end
            ppid_pkg::OP_EMIT: begin
                if (!o_stat.out_busy) begin
                    r_drive <= clamp(quot, i_output_floor, i_output_ceiling);
                end
            end
            default: begin
            end
        endcase
    end

    assign o_stat.div_more = (r_cnt != ppid_pkg::CNT_W'(ppid_pkg::DIV_STEPS - 1));
    assign o_stat.out_busy = r_out_valid && !i_out_ready;
    assign o_out_valid     = r_out_valid;
    assign o_drive         = r_drive;

endmodule

FILE: rtl/core/positional_pid_controller_top.sv
// Positional PID controller: each item (setpoint, measured) gives one drive value,
// (gain_p*e + gain_i*integral + gain_d*(e - previous e)) saturated to 32 bits, divided by
// divisor toward zero and clamped. Items are handled one at a time: each item runs
// through the nine single steps and the 32-step serial divider of the microprogram,
// and the next item is taken only once the program is back in its wait step. A result
// left untaken in the output register stalls the program only when the following result
// is ready. The user must write registers over the APB port only while the block is
// idle; the block itself does not enforce this. Reset clears the stored error and
// integral.
module positional_pid_controller_top #(
    parameter int SAMPLE_WIDTH = 16,
    parameter int GAIN_WIDTH   = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic signed [SAMPLE_WIDTH-1:0] i_setpoint,
    input  logic signed [SAMPLE_WIDTH-1:0] i_measured,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic signed [31:0]             o_drive,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [4:0]                     paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready
);

    localparam logic [2:0] REG_GAIN_P  = 3'd0;
    localparam logic [2:0] REG_GAIN_I  = 3'd1;
    localparam logic [2:0] REG_GAIN_D  = 3'd2;
    localparam logic [2:0] REG_DIVISOR = 3'd3;
    localparam logic [2:0] REG_INT_LO  = 3'd4;
    localparam logic [2:0] REG_INT_HI  = 3'd5;
    localparam logic [2:0] REG_OUT_LO  = 3'd6;
    localparam logic [2:0] REG_OUT_HI  = 3'd7;

    localparam int DW = ppid_pkg::DATA_W;
    localparam int QW = ppid_pkg::DIV_W;

    logic signed [GAIN_WIDTH-1:0] r_gain_p;
    logic signed [GAIN_WIDTH-1:0] r_gain_i;
    logic signed [GAIN_WIDTH-1:0] r_gain_d;
    logic [QW-1:0]                r_divisor;
    logic signed [DW-1:0]         r_int_lo;
    logic signed [DW-1:0]         r_int_hi;
    logic signed [DW-1:0]         r_out_lo;
    logic signed [DW-1:0]         r_out_hi;

    logic            wr_en;
    logic [2:0]      reg_idx;
    ppid_pkg::t_ctrl ctrl;
    ppid_pkg::t_stat stat;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = paddr[4:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain_p  <= '0;
            r_gain_i  <= '0;
            r_gain_d  <= '0;
            r_divisor <= QW'(1);
            r_int_lo  <= '0;
            r_int_hi  <= '0;
            r_out_lo  <= '0;
            r_out_hi  <= '0;
        end else if (wr_en) begin
            case (reg_idx)
                REG_GAIN_P:  r_gain_p <= pwdata[GAIN_WIDTH-1:0];
                REG_GAIN_I:  r_gain_i <= pwdata[GAIN_WIDTH-1:0];
                REG_GAIN_D:  r_gain_d <= pwdata[GAIN_WIDTH-1:0];
                // a zero divisor is stored as one
                REG_DIVISOR: r_divisor <= (pwdata[QW-1:0] == '0) ? QW'(1) : pwdata[QW-1:0];
                REG_INT_LO:  r_int_lo <= pwdata;
                REG_INT_HI:  r_int_hi <= pwdata;
                REG_OUT_LO:  r_out_lo <= pwdata;
                REG_OUT_HI:  r_out_hi <= pwdata;
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_GAIN_P:  prdata = DW'(r_gain_p);
            REG_GAIN_I:  prdata = DW'(r_gain_i);
            REG_GAIN_D:  prdata = DW'(r_gain_d);
            REG_DIVISOR: prdata = DW'(r_divisor);
            REG_INT_LO:  prdata = r_int_lo;
            REG_INT_HI:  prdata = r_int_hi;
            REG_OUT_LO:  prdata = r_out_lo;
            REG_OUT_HI:  prdata = r_out_hi;
            default:     prdata = '0;
        endcase
    end

    ppid_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_stat     (stat),
        .o_ctrl     (ctrl),
        .o_in_ready (o_in_ready)
    );

    ppid_dp #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .GAIN_WIDTH   (GAIN_WIDTH)
    ) u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_ctrl             (ctrl),
        .i_in_valid         (i_in_valid),
        .i_setpoint         (i_setpoint),
        .i_measured         (i_measured),
        .i_gain_p           (r_gain_p),
        .i_gain_i           (r_gain_i),
        .i_gain_d           (r_gain_d),
        .i_divisor          (r_divisor),
        .i_integral_floor   (r_int_lo),
        .i_integral_ceiling (r_int_hi),
        .i_output_floor     (r_out_lo),
        .i_output_ceiling   (r_out_hi),
        .i_out_ready        (i_out_ready),
        .o_stat             (stat),
        .o_out_valid        (o_out_valid),
        .o_drive            (o_drive)
    );

endmodule

FILE: rtl/core/ppid_chk.sv
module ppid_chk (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_ready,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input logic signed [31:0] o_drive
);

    // a result stays on offer, unchanged, until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_drive))
        else $error("result dropped or changed while stalled");

    // one item at a time: no second item straight after an accepted one
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("input taken while an item is in work");

    // a result cannot appear straight after its item is accepted
    a_no_early: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !$rose(o_out_valid) ##1 !$rose(o_out_valid))
        else $error("result appeared too early");

    // reset empties the output register
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind positional_pid_controller_top ppid_chk u_ppid_chk (.*);

FILE: tb/sv/tb.sv
module tb;

    localparam int INT_MAX      = 2147483647;
    localparam int INT_MIN      = -2147483647 - 1;
    localparam int NUM_PHASES   = 16;
    localparam int PHASE_ITEMS  = 117;
    localparam int HOLD_CYCLES  = 400;
    localparam int QUIET_LIMIT  = 4000;
    localparam int DRAIN_CYCLES = 60;
    localparam int MAX_GAP      = 20;
    localparam logic signed [15:0] SAMPLE_MAX = 16'sh7fff;
    localparam logic signed [15:0] SAMPLE_MIN = 16'sh8000;

    typedef enum logic [2:0] {
        REG_GAIN_P, REG_GAIN_I, REG_GAIN_D, REG_DIVISOR,
        REG_INT_FLOOR, REG_INT_CEIL, REG_OUT_FLOOR, REG_OUT_CEIL
    } reg_e;

    typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_e;

    typedef struct {
        row_kind_e          kind;
        reg_e               idx;
        int                 value;
        logic signed [15:0] sp;
        logic signed [15:0] ms;
        bit                 known;
        logic signed [31:0] drive;
    } plan_row_t;

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_ready;
    logic signed [15:0] i_setpoint;
    logic signed [15:0] i_measured;
    logic               o_out_valid;
    logic               i_out_ready;
    logic signed [31:0] o_drive;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [4:0]         paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;

    // controller settings and state as the block should hold them
    logic signed [15:0] cfg_kp = '0;
    logic signed [15:0] cfg_ki = '0;
    logic signed [15:0] cfg_kd = '0;
    logic [15:0]        cfg_div = 16'd1;
    logic signed [31:0] cfg_int_lo = '0;
    logic signed [31:0] cfg_int_hi = '0;
    logic signed [31:0] cfg_out_lo = '0;
    logic signed [31:0] cfg_out_hi = '0;
    logic signed [16:0] prev_err = '0;
    logic signed [31:0] integ = '0;

    logic signed [31:0] pending_drive [$];
    plan_row_t          plan [$];

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    bit hold_req       = 1'b0;
    int fail_cnt       = 0;
    int quiet_cycles   = 0;

    positional_pid_controller_top uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_setpoint  (i_setpoint),
        .i_measured  (i_measured),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_drive     (o_drive),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic longint sat32(input longint v);
        if (v > longint'(INT_MAX)) return longint'(INT_MAX);
        if (v < longint'(INT_MIN)) return longint'(INT_MIN);
        return v;
    endfunction

    // bounds only bite when properly ordered
    function automatic longint clamp_to(input longint v, input longint lo, input longint hi);
        if (lo < hi) begin
            if (v > hi) return hi;
            if (v < lo) return lo;
        end
        return v;
    endfunction

    function automatic logic signed [31:0] predict_drive(input logic signed [15:0] sp,
                                                         input logic signed [15:0] ms);
        longint err;
        longint der;
        longint sum;
        longint acc;
        longint q;
        err = longint'(sp) - longint'(ms);
        der = err - longint'(prev_err);
        prev_err = 17'(err);
        sum = clamp_to(sat32(longint'(integ) + err), longint'(cfg_int_lo), longint'(cfg_int_hi));
        integ = 32'(sum);
        acc = longint'(cfg_kp) * err + longint'(cfg_ki) * sum + longint'(cfg_kd) * der;
        q = sat32(acc) / longint'(cfg_div);
        q = clamp_to(q, longint'(cfg_out_lo), longint'(cfg_out_hi));
        return 32'(q);
    endfunction

    function automatic plan_row_t cfg_row(input reg_e idx, input int value);
        plan_row_t r;
        r = '{kind: ROW_CFG, idx: idx, value: value, sp: '0, ms: '0, known: 1'b0, drive: '0};
        return r;
    endfunction

    function automatic plan_row_t item_row(input int sp, input int ms, input bit known,
                                           input int drive);
        plan_row_t r;
        r = '{kind: ROW_ITEM, idx: REG_GAIN_P, value: 0, sp: 16'(sp), ms: 16'(ms),
              known: known, drive: drive};
        return r;
    endfunction

    function automatic int pick_gain();
        case ($urandom_range(5))
            0: return -32768;
            1: return 32767;
            2: return 0;
            3, 4: return int'($urandom_range(64)) - 32;
            default: return int'($signed(16'($urandom)));
        endcase
    endfunction

    task automatic pick_bounds(output int lo, output int hi);
        int a;
        int b;
        a = int'($urandom_range(2000)) - 1000;
        b = a + int'($urandom_range(3000));
        case ($urandom_range(4))
            0: begin
                lo = 0;
                hi = 0;
            end
            1: begin
                lo = b;
                hi = a;
            end
            2: begin
                lo = a;
                hi = b;
            end
            3: begin
                lo = INT_MIN;
                hi = INT_MAX;
            end
            default: begin
                lo = int'($urandom);
                hi = int'($urandom);
            end
        endcase
    endtask

    // called at a falling edge, returns at one
    task automatic write_reg(input reg_e idx, input int value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        case (idx)
            REG_GAIN_P:    cfg_kp = value[15:0];
            REG_GAIN_I:    cfg_ki = value[15:0];
            REG_GAIN_D:    cfg_kd = value[15:0];
            REG_DIVISOR:   cfg_div = (value[15:0] == 16'd0) ? 16'd1 : value[15:0];
            REG_INT_FLOOR: cfg_int_lo = value;
            REG_INT_CEIL:  cfg_int_hi = value;
            REG_OUT_FLOOR: cfg_out_lo = value;
            REG_OUT_CEIL:  cfg_out_hi = value;
            default: ;
        endcase
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // called at a falling edge; valid stays up into the next item unless a gap follows or no item comes next
    task automatic offer_sample(input logic signed [15:0] sp, input logic signed [15:0] ms,
                                input bit known, input logic signed [31:0] typed,
                                input bit more);
        logic signed [31:0] want;
        int gap;
        i_in_valid <= 1'b1;
        i_setpoint <= sp;
        i_measured <= ms;
        do @(posedge i_clk); while (!o_in_ready);
        want = predict_drive(sp, ms);
        pending_drive.push_back(known ? typed : want);
        gap = 0;
        while (gap < MAX_GAP && $urandom_range(99) < send_idle_pct) gap++;
        @(negedge i_clk);
        if (!more || gap > 0) i_in_valid <= 1'b0;
        repeat (gap) @(negedge i_clk);
    endtask

    task automatic wait_drained();
        while (pending_drive.size() != 0) @(posedge i_clk);
    endtask

    // receiver side, with one long hold-off to back the block up
    initial begin
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                i_out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_req = 1'b0;
            end
            i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        logic signed [31:0] want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_drive.size() == 0) begin
                $error("drive: no item pending, got %0d", o_drive);
                fail_cnt++;
            end else begin
                want = pending_drive.pop_front();
                if (o_drive !== want) begin
                    $error("drive: expected %0d, got %0d", want, o_drive);
                    fail_cnt++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) || (psel && penable))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial begin
        while (quiet_cycles < QUIET_LIMIT) @(posedge i_clk);
        $display("positional_pid_controller_top test failed");
        $finish;
    end

    initial begin
        int                 ph;
        int                 n;
        int                 r;
        int                 mode;
        int                 vals [8];
        int                 i_lo;
        int                 i_hi;
        int                 o_lo;
        int                 o_hi;
        logic signed [15:0] sp;
        logic signed [15:0] ms;
        bit                 more;

        i_rst_n    = 1'b0;
        i_in_valid = 1'b0;
        i_setpoint = '0;
        i_measured = '0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;

        // gains are zero out of reset
        plan.push_back(item_row(0, 0, 1, 0));
        plan.push_back(item_row(32767, -32768, 1, 0));
        plan.push_back(cfg_row(REG_GAIN_P, 1));
        plan.push_back(item_row(32767, -32768, 1, 65535));
        plan.push_back(item_row(-32768, 32767, 1, -65535));
        // weighted sum past 32 bits both ways
        plan.push_back(cfg_row(REG_GAIN_P, 32767));
        plan.push_back(cfg_row(REG_GAIN_D, 32767));
        plan.push_back(item_row(32767, -32768, 1, INT_MAX));
        plan.push_back(item_row(-32768, 32767, 1, INT_MIN));
        // zero divisor behaves as one, then the largest divisor
        plan.push_back(cfg_row(REG_GAIN_P, 1));
        plan.push_back(cfg_row(REG_GAIN_D, 0));
        plan.push_back(cfg_row(REG_DIVISOR, 0));
        plan.push_back(item_row(100, 0, 1, 100));
        plan.push_back(cfg_row(REG_DIVISOR, 65535));
        plan.push_back(item_row(32767, -32768, 1, 1));
        plan.push_back(item_row(-32768, 32767, 1, -1));
        // division truncates toward zero, then the output clamp
        plan.push_back(cfg_row(REG_DIVISOR, 7));
        plan.push_back(item_row(-10, 0, 1, -1));
        plan.push_back(item_row(10, 0, 1, 1));
        plan.push_back(cfg_row(REG_DIVISOR, 1));
        plan.push_back(cfg_row(REG_OUT_FLOOR, -5));
        plan.push_back(cfg_row(REG_OUT_CEIL, 5));
        plan.push_back(item_row(100, 0, 1, 5));
        plan.push_back(item_row(-100, 0, 1, -5));
        plan.push_back(item_row(3, 0, 1, 3));
        // output clamp off when inverted or equal
        plan.push_back(cfg_row(REG_OUT_FLOOR, 5));
        plan.push_back(cfg_row(REG_OUT_CEIL, -5));
        plan.push_back(item_row(100, 0, 1, 100));
        plan.push_back(cfg_row(REG_OUT_CEIL, 5));
        plan.push_back(item_row(-100, 0, 1, -100));
        // integral pulled up to its floor, then saturating at the top
        plan.push_back(cfg_row(REG_GAIN_P, 0));
        plan.push_back(cfg_row(REG_GAIN_I, 1));
        plan.push_back(cfg_row(REG_OUT_FLOOR, 0));
        plan.push_back(cfg_row(REG_OUT_CEIL, 0));
        plan.push_back(cfg_row(REG_INT_FLOOR, 2147483000));
        plan.push_back(cfg_row(REG_INT_CEIL, INT_MAX));
        plan.push_back(item_row(0, 0, 1, 2147483000));
        plan.push_back(item_row(32767, -32768, 1, INT_MAX));
        plan.push_back(cfg_row(REG_INT_FLOOR, 0));
        plan.push_back(cfg_row(REG_INT_CEIL, 0));
        plan.push_back(item_row(1, 0, 1, INT_MAX));
        plan.push_back(item_row(-1, 0, 1, 2147483646));
        // and at the bottom
        plan.push_back(cfg_row(REG_INT_FLOOR, INT_MIN));
        plan.push_back(cfg_row(REG_INT_CEIL, -2147483000));
        plan.push_back(item_row(0, 0, 1, -2147483000));
        plan.push_back(item_row(-32768, 32767, 1, INT_MIN));
        plan.push_back(cfg_row(REG_INT_FLOOR, -100));
        plan.push_back(cfg_row(REG_INT_CEIL, 100));
        plan.push_back(item_row(0, 0, 1, -100));
        plan.push_back(item_row(32767, 0, 1, 100));
        plan.push_back(cfg_row(REG_GAIN_P, 32767));
        plan.push_back(cfg_row(REG_GAIN_I, -32768));
        plan.push_back(cfg_row(REG_GAIN_D, -32768));
        plan.push_back(cfg_row(REG_DIVISOR, 3));
        plan.push_back(cfg_row(REG_INT_FLOOR, 0));
        plan.push_back(cfg_row(REG_INT_CEIL, 0));
        plan.push_back(item_row(12345, -4321, 0, 0));

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (n = 0; n < plan.size(); n++) begin
            if (plan[n].kind == ROW_CFG) begin
                wait_drained();
                write_reg(plan[n].idx, plan[n].value);
            end else begin
                more = (n + 1 < plan.size()) && (plan[n + 1].kind == ROW_ITEM);
                offer_sample(plan[n].sp, plan[n].ms, plan[n].known, plan[n].drive, more);
            end
        end

        for (ph = 0; ph < NUM_PHASES; ph++) begin
            // none, sender idle, receiver stalling, both
            mode = ph % 4;
            send_idle_pct  = (mode == 1) ? 53 : (mode == 3) ? 22 : 0;
            recv_stall_pct = (mode == 2) ? 53 : (mode == 3) ? 22 : 0;

            pick_bounds(i_lo, i_hi);
            pick_bounds(o_lo, o_hi);
            vals[REG_GAIN_P]    = pick_gain();
            vals[REG_GAIN_I]    = pick_gain();
            vals[REG_GAIN_D]    = pick_gain();
            case ($urandom_range(4))
                0: vals[REG_DIVISOR] = 0;
                1: vals[REG_DIVISOR] = 1;
                2: vals[REG_DIVISOR] = 65535;
                3: vals[REG_DIVISOR] = int'($urandom_range(300, 2));
                default: vals[REG_DIVISOR] = int'($urandom_range(65535));
            endcase
            vals[REG_INT_FLOOR] = i_lo;
            vals[REG_INT_CEIL]  = i_hi;
            vals[REG_OUT_FLOOR] = o_lo;
            vals[REG_OUT_CEIL]  = o_hi;
            if (ph == 0) begin
                vals[REG_GAIN_P]    = 32767;
                vals[REG_GAIN_I]    = 32767;
                vals[REG_GAIN_D]    = 32767;
                vals[REG_DIVISOR]   = 1;
                vals[REG_INT_FLOOR] = INT_MIN;
                vals[REG_INT_CEIL]  = INT_MAX;
                vals[REG_OUT_FLOOR] = INT_MIN;
                vals[REG_OUT_CEIL]  = INT_MAX;
            end else if (ph == 1) begin
                vals[REG_GAIN_P]    = -32768;
                vals[REG_GAIN_I]    = -32768;
                vals[REG_GAIN_D]    = -32768;
                vals[REG_DIVISOR]   = 65535;
                vals[REG_INT_FLOOR] = INT_MAX;
                vals[REG_INT_CEIL]  = INT_MIN;
                vals[REG_OUT_FLOOR] = INT_MAX;
                vals[REG_OUT_CEIL]  = INT_MIN;
            end

            wait_drained();
            for (r = 0; r < 8; r++) write_reg(reg_e'(r), vals[r]);

            if (ph == 4) hold_req = 1'b1;

            for (n = 0; n < PHASE_ITEMS; n++) begin
                case ($urandom_range(7))
                    0: begin
                        sp = $urandom_range(1) ? SAMPLE_MAX : SAMPLE_MIN;
                        ms = $urandom_range(1) ? SAMPLE_MAX : SAMPLE_MIN;
                    end
                    1, 2: begin
                        sp = 16'(int'($urandom_range(400)) - 200);
                        ms = 16'(int'($urandom_range(400)) - 200);
                    end
                    default: begin
                        sp = 16'($urandom);
                        ms = 16'($urandom);
                    end
                endcase
                offer_sample(sp, ms, 1'b0, '0, n < PHASE_ITEMS - 1);
            end
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_cnt == 0)
            $display("positional_pid_controller_top test passed");
        else
            $display("positional_pid_controller_top test failed");
        $finish;
    end

endmodule
